[design/pagerank_power_iteration_assert.svh]
// Assertion macros for the PageRank power-iteration block.
`ifndef PAGERANK_POWER_ITERATION_ASSERT_SVH
`define PAGERANK_POWER_ITERATION_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define PGR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define PGR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PGR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PGR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[design/pgr_pkg.sv]
// Shared types and constants of the PageRank power-iteration block.
package pgr_pkg;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_RUN   = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
   localparam logic [1:0] REG_DAMPING      = 2'd1;
   localparam logic [1:0] REG_ITER_LIMIT   = 2'd2;
   localparam logic [1:0] REG_TOLERANCE    = 2'd3;

   localparam logic [15:0] ONE_Q15 = 16'h8000;
   localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

   typedef enum logic [4:0] {
      S_IDLE,
      S_EDGE_RD,
      S_EDGE_WR,
      S_READ_WAIT,
      S_INIT_WAIT,
      S_INIT_WR,
      S_BASE_WAIT,
      S_V_RD,
      S_V_MUL,
      S_V_DIV,
      S_V_WAIT,
      S_E_RD,
      S_E_CHK,
      S_E_ACC,
      S_F_RD,
      S_F_SAT,
      S_F_WR,
      S_PASS_END,
      S_RESP
   } state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

[design/pgr_if.sv]
// Request and response channel interfaces.
interface pgr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] source_vertex;
   logic [7:0] target_vertex;
   modport source (output valid, action, source_vertex, target_vertex, input ready);
   modport sink (input valid, action, source_vertex, target_vertex, output ready);
endinterface

interface pgr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] rank_value;
   logic [15:0] iterations_done;
   logic        converged;
   modport source (output valid, status, rank_value, iterations_done, converged,
                   input ready);
   modport sink (input valid, status, rank_value, iterations_done, converged,
                 output ready);
endinterface

[design/pagerank_power_iteration.sv]
// PageRank power iteration over a stored edge list. Edges are added one per
// item and counted into per-vertex out-degrees; other items read a rank or
// clear the edge list. A run item sets all ranks
// to 1/N and then repeats passes until the L1 change drops below tolerance or
// the iteration limit is hit. Every division goes through one shared
// restoring divider. After the set-up, each pass computes the per-vertex
// shares, scatters them over the stored edges, and then updates the ranks and
// sums the difference. The block takes no new item while a run is in progress;
// a finished result waits in the output register while the next item is taken.
module pagerank_power_iteration
   import pgr_pkg::*;
#(
   parameter int MAX_VERTICES = 256,
   parameter int MAX_EDGES    = 4096
) (
   input  logic         clock,
   input  logic         reset,
   pgr_req_if.sink      req,
   pgr_rsp_if.source    rsp,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

`include "pagerank_power_iteration_assert.svh"

   localparam int VW   = $clog2(MAX_VERTICES);            // vertex address
   localparam int NW   = $clog2(MAX_VERTICES + 1);        // vertex count
   localparam int EW   = $clog2(MAX_EDGES + 1);           // edge count / degree
   localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int SPW  = 32 + NW;                         // dangling spread sum
   localparam int ACCW = 33 + EW;                         // per-vertex accumulator
   localparam int DFW  = 32 + NW;                         // L1 difference
   localparam int XW   = ((ACCW > SPW) ? ACCW : SPW) + 1;

   // ---------------- configuration registers ----------------
   logic [8:0]  vcount_ff;
   logic [15:0] damping_ff;
   logic [15:0] limit_ff;
   logic [31:0] tol_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff  <= '0;
         damping_ff <= 16'd27853;
         limit_ff   <= 16'd100;
         tol_ff     <= 32'd2147;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_VERTEX_COUNT: vcount_ff  <= pwdata[8:0];
            REG_DAMPING:      damping_ff <= pwdata[15:0];
            REG_ITER_LIMIT:   limit_ff   <= pwdata[15:0];
            REG_TOLERANCE:    tol_ff     <= pwdata;
            default:          ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_VERTEX_COUNT: prdata = {23'd0, vcount_ff};
         REG_DAMPING:      prdata = {16'd0, damping_ff};
         REG_ITER_LIMIT:   prdata = {16'd0, limit_ff};
         REG_TOLERANCE:    prdata = tol_ff;
         default:          prdata = '0;
      endcase
   end

   // N clipped to the vertex store; damping clipped to one.
   logic [NW-1:0] n_eff;
   logic [15:0]   d_eff;
   assign n_eff = (32'(vcount_ff) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcount_ff);
   assign d_eff = (damping_ff > ONE_Q15) ? ONE_Q15 : damping_ff;

   // ---------------- stores ----------------
   logic [31:0]     rank_mem [MAX_VERTICES];
   logic [ACCW-1:0] acc_mem  [MAX_VERTICES];
   logic [31:0]     ctb_mem  [MAX_VERTICES];   // per-edge share of each vertex
   logic [EW-1:0]   deg_mem  [MAX_VERTICES];
   logic [15:0]     edge_mem [MAX_EDGES];      // {source, target}
   logic            deg_vld_ff [MAX_VERTICES];

   logic            rank_we, acc_we, ctb_we, deg_we, edge_we, deg_clr;
   logic [VW-1:0]   rank_wa, rank_ra, acc_wa, acc_ra, ctb_wa, ctb_ra, deg_wa, deg_ra;
   logic [EAW-1:0]  edge_wa, edge_ra;
   logic [31:0]     rank_wd, ctb_wd;
   logic [ACCW-1:0] acc_wd;
   logic [EW-1:0]   deg_wd;
   logic [15:0]     edge_wd;

   logic [31:0]     rank_rd_ff, ctb_rd_ff;
   logic [ACCW-1:0] acc_rd_ff;
   logic [EW-1:0]   deg_rd_ff;
   logic            deg_vld_rd_ff;
   logic [15:0]     edge_rd_ff;

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[rank_wa] <= rank_wd;
      end
      rank_rd_ff <= rank_mem[rank_ra];
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_wa] <= acc_wd;
      end
      acc_rd_ff <= acc_mem[acc_ra];
   end

   always_ff @(posedge clock) begin
      if (ctb_we) begin
         ctb_mem[ctb_wa] <= ctb_wd;
      end
      ctb_rd_ff <= ctb_mem[ctb_ra];
   end

   always_ff @(posedge clock) begin
      if (deg_we) begin
         deg_mem[deg_wa] <= deg_wd;
      end
      deg_rd_ff     <= deg_mem[deg_ra];
      deg_vld_rd_ff <= deg_vld_ff[deg_ra];
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_wa] <= edge_wd;
      end
      edge_rd_ff <= edge_mem[edge_ra];
   end

   // Valid bit per out-degree entry: an entry not valid reads as zero.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         if (reset || deg_clr) begin
            deg_vld_ff[i] <= 1'b0;
         end else if (deg_we && (deg_wa == VW'(i))) begin
            deg_vld_ff[i] <= 1'b1;
         end
      end
   end

   logic [EW-1:0] deg_val;
   assign deg_val = deg_vld_rd_ff ? deg_rd_ff : '0;

   // ---------------- shared divider ----------------
   div_req_type dreq;
   div_rsp_type drsp;

   pgr_div u_div (
      .clock (clock),
      .reset (reset),
      .dreq  (dreq),
      .drsp  (drsp)
   );

   // ---------------- sequencer ----------------
   state_type       state_ff, state_in;
   logic [1:0]      status_ff, status_in;
   logic [31:0]     rank_out_ff, rank_out_in;
   logic [15:0]     last_iter_ff, last_iter_in;
   logic            last_conv_ff, last_conv_in;
   logic [EW-1:0]   edge_cnt_ff, edge_cnt_in;
   logic [7:0]      src_ff, src_in;
   logic [7:0]      tgt_ff, tgt_in;
   logic [NW-1:0]   v_ff, v_in;
   logic [EW-1:0]   e_ff, e_in;
   logic [31:0]     base_ff, base_in;
   logic [SPW-1:0]  spread_ff, spread_in;
   logic [DFW-1:0]  diff_ff, diff_in;
   logic [31:0]     prod_ff, prod_in;
   logic [EW-1:0]   degv_ff, degv_in;
   logic [31:0]     nx_ff, nx_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic [31:0]     rsp_rank_ff, rsp_rank_in;
   logic [15:0]     rsp_iter_ff, rsp_iter_in;
   logic            rsp_conv_ff, rsp_conv_in;

   logic [47:0]     prod_full;
   logic [XW-1:0]   x_sum;
   logic            src_bad, tgt_bad, v_last, e_last, e_src_ok, e_tgt_ok;
   logic [15:0]     iter_next;

   assign prod_full = {32'd0, d_eff} * {16'd0, rank_rd_ff};
   assign x_sum     = XW'(acc_rd_ff) + XW'(spread_ff);
   assign src_bad   = 32'(req.source_vertex) >= 32'(n_eff);
   assign tgt_bad   = 32'(req.target_vertex) >= 32'(n_eff);
   assign v_last    = (v_ff == (n_eff - NW'(1)));
   assign e_last    = (e_ff == (edge_cnt_ff - EW'(1)));
   assign e_src_ok  = 32'(edge_rd_ff[15:8]) < 32'(n_eff);
   assign e_tgt_ok  = 32'(edge_rd_ff[7:0]) < 32'(n_eff);
   assign iter_next = last_iter_ff + 16'd1;

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      rank_out_in  = rank_out_ff;
      last_iter_in = last_iter_ff;
      last_conv_in = last_conv_ff;
      edge_cnt_in  = edge_cnt_ff;
      src_in       = src_ff;
      tgt_in       = tgt_ff;
      v_in         = v_ff;
      e_in         = e_ff;
      base_in      = base_ff;
      spread_in    = spread_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      degv_in      = degv_ff;
      nx_in        = nx_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_iter_in   = rsp_iter_ff;
      rsp_conv_in   = rsp_conv_ff;

      rank_we = 1'b0; rank_wa = v_ff[VW-1:0]; rank_wd = nx_ff; rank_ra = v_ff[VW-1:0];
      acc_we  = 1'b0; acc_wa  = v_ff[VW-1:0]; acc_wd  = ACCW'(base_ff);
      acc_ra  = v_ff[VW-1:0];
      ctb_we  = 1'b0; ctb_wa  = v_ff[VW-1:0]; ctb_wd  = drsp.quotient;
      ctb_ra  = v_ff[VW-1:0];
      deg_we  = 1'b0; deg_wa  = VW'(src_ff);  deg_wd  = deg_val + EW'(1);
      deg_ra  = v_ff[VW-1:0];
      deg_clr = 1'b0;
      edge_we = 1'b0; edge_wa = edge_cnt_ff[EAW-1:0]; edge_wd = {src_ff, tgt_ff};
      edge_ra = e_ff[EAW-1:0];

      dreq.start    = 1'b0;
      dreq.dividend = prod_ff;
      dreq.divisor  = (degv_ff == '0) ? 32'(n_eff) : 32'(degv_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               src_in      = req.source_vertex;
               tgt_in      = req.target_vertex;
               status_in   = ST_OK;
               rank_out_in = '0;
               unique case (req.action)
                  ACT_ADD: begin
                     if (src_bad || tgt_bad) begin
                        status_in = ST_RANGE;
                        state_in  = S_RESP;
                     end else if (32'(edge_cnt_ff) >= 32'(MAX_EDGES)) begin
                        status_in = ST_FULL;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_EDGE_RD;
                     end
                  end
                  ACT_RUN: begin
                     last_iter_in = '0;
                     last_conv_in = 1'b0;
                     if (n_eff == '0) begin
                        state_in = S_RESP;
                     end else begin
                        dreq.start    = 1'b1;
                        dreq.dividend = ONE_Q31;
                        dreq.divisor  = 32'(n_eff);
                        state_in      = S_INIT_WAIT;
                     end
                  end
                  ACT_READ: begin
                     if (src_bad) begin
                        status_in = ST_RANGE;
                        state_in  = S_RESP;
                     end else begin
                        rank_ra  = VW'(req.source_vertex);
                        state_in = S_READ_WAIT;
                     end
                  end
                  ACT_CLEAR: begin
                     edge_cnt_in = '0;
                     deg_clr     = 1'b1;
                     state_in    = S_RESP;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_EDGE_RD: begin
            edge_we     = 1'b1;
            edge_cnt_in = edge_cnt_ff + EW'(1);
            deg_ra      = VW'(src_ff);
            state_in    = S_EDGE_WR;
         end
         S_EDGE_WR: begin
            deg_we   = 1'b1;
            state_in = S_RESP;
         end
         S_READ_WAIT: begin
            rank_out_in = rank_rd_ff;
            state_in    = S_RESP;
         end
         S_INIT_WAIT: begin
            if (drsp.done) begin
               v_in     = '0;
               state_in = S_INIT_WR;
            end
         end
         S_INIT_WR: begin
            rank_we = 1'b1;
            rank_wd = drsp.quotient;
            if (v_last) begin
               if (limit_ff == '0) begin
                  state_in = S_RESP;
               end else begin
                  dreq.start    = 1'b1;
                  dreq.dividend = {ONE_Q15 - d_eff, 16'd0};
                  dreq.divisor  = 32'(n_eff);
                  state_in      = S_BASE_WAIT;
               end
            end else begin
               v_in = v_ff + NW'(1);
            end
         end
         S_BASE_WAIT: begin
            if (drsp.done) begin
               base_in   = drsp.quotient;
               spread_in = '0;
               v_in      = '0;
               state_in  = S_V_RD;
            end
         end
         S_V_RD: begin
            state_in = S_V_MUL;
         end
         S_V_MUL: begin
            prod_in  = prod_full[46:15];
            degv_in  = deg_val;
            state_in = S_V_DIV;
         end
         S_V_DIV: begin
            // dangling vertices divide by N, others by their out-degree
            dreq.start = 1'b1;
            acc_we     = 1'b1;
            state_in   = S_V_WAIT;
         end
         S_V_WAIT: begin
            if (drsp.done) begin
               ctb_we = 1'b1;
               if (degv_ff == '0) begin
                  ctb_wd    = '0;
                  spread_in = spread_ff + SPW'(drsp.quotient);
               end
               if (v_last) begin
                  v_in    = '0;
                  e_in    = '0;
                  diff_in = '0;
                  state_in = (edge_cnt_ff == '0) ? S_F_RD : S_E_RD;
               end else begin
                  v_in     = v_ff + NW'(1);
                  state_in = S_V_RD;
               end
            end
         end
         S_E_RD: begin
            state_in = S_E_CHK;
         end
         S_E_CHK: begin
            if (e_src_ok && e_tgt_ok) begin
               ctb_ra   = VW'(edge_rd_ff[15:8]);
               acc_ra   = VW'(edge_rd_ff[7:0]);
               tgt_in   = edge_rd_ff[7:0];
               state_in = S_E_ACC;
            end else if (e_last) begin
               state_in = S_F_RD;
            end else begin
               e_in     = e_ff + EW'(1);
               state_in = S_E_RD;
            end
         end
         S_E_ACC: begin
            acc_we = 1'b1;
            acc_wa = VW'(tgt_ff);
            acc_wd = acc_rd_ff + ACCW'(ctb_rd_ff);
            if (e_last) begin
               state_in = S_F_RD;
            end else begin
               e_in     = e_ff + EW'(1);
               state_in = S_E_RD;
            end
         end
         S_F_RD: begin
            state_in = S_F_SAT;
         end
         S_F_SAT: begin
            nx_in    = (x_sum > XW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : x_sum[31:0];
            state_in = S_F_WR;
         end
         S_F_WR: begin
            rank_we = 1'b1;
            diff_in = diff_ff + DFW'((nx_ff >= rank_rd_ff) ? (nx_ff - rank_rd_ff)
                                                           : (rank_rd_ff - nx_ff));
            if (v_last) begin
               state_in = S_PASS_END;
            end else begin
               v_in     = v_ff + NW'(1);
               state_in = S_F_RD;
            end
         end
         S_PASS_END: begin
            last_iter_in = iter_next;
            if (diff_ff < DFW'(tol_ff)) begin
               last_conv_in = 1'b1;
               state_in     = S_RESP;
            end else if (iter_next == limit_ff) begin
               state_in = S_RESP;
            end else begin
               v_in      = '0;
               spread_in = '0;
               state_in  = S_V_RD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_rank_in   = rank_out_ff;
               rsp_iter_in   = last_iter_ff;
               rsp_conv_in   = last_conv_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_iter_ff <= '0;
         last_conv_ff <= 1'b0;
         edge_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_iter_ff <= last_iter_in;
         last_conv_ff <= last_conv_in;
         edge_cnt_ff  <= edge_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      rank_out_ff   <= rank_out_in;
      src_ff        <= src_in;
      tgt_ff        <= tgt_in;
      v_ff          <= v_in;
      e_ff          <= e_in;
      base_ff       <= base_in;
      spread_ff     <= spread_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      degv_ff       <= degv_in;
      nx_ff         <= nx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_iter_ff   <= rsp_iter_in;
      rsp_conv_ff   <= rsp_conv_in;
   end

   assign req.ready           = (state_ff == S_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.rank_value      = rsp_rank_ff;
   assign rsp.iterations_done = rsp_iter_ff;
   assign rsp.converged       = rsp_conv_ff;

   // ---------------- checks ----------------
   `PGR_ASSERT_IMP(a_edge_cnt_bound, clock, reset, 1'b1, 32'(edge_cnt_ff) <= 32'(MAX_EDGES), "edge count beyond store")
   `PGR_ASSERT_IMP(a_conv_has_pass, clock, reset, last_conv_ff, last_iter_ff != '0, "converged with no pass")
   `PGR_ASSERT_IMP(a_div_nonzero, clock, reset, dreq.start, dreq.divisor != '0, "divide by zero")
   `PGR_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req.valid && req.ready, state_ff != S_IDLE, "item not taken up")

endmodule

[design/pgr_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module pgr_div
   import pgr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type dreq,
   output div_rsp_type drsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] rem_sh;
   logic        fits;

   assign rem_sh = {rem_ff[31:0], quo_ff[31]};
   assign fits   = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (dreq.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dreq.dividend;
         dvs_in  = dreq.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign drsp.done     = done_ff;
   assign drsp.quotient = quo_ff;

endmodule
